/* rtl/sapsel_pkg.sv */
`default_nettype none

package sapsel_pkg;

    // Number of points kept per scan and reported at most.
    localparam int MAX_REPORT = 15;
    // Index of one cell in the chain.
    localparam int IDX_W = (MAX_REPORT > 1) ? $clog2(MAX_REPORT) : 1;
    // Number of words still to be reported, up to MAX_REPORT.
    localparam int LEFT_W = $clog2(MAX_REPORT + 1);
    // Points seen in one scan; saturates.
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [47:0]        address;
        logic signed [7:0]  strength;
        logic [7:0]         channel;
    } t_entry;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic   valid;
        logic   take;
        t_entry ranked;
        t_entry arrival;
    } t_link;

endpackage

`default_nettype wire

/* rtl/sapsel_cell.sv */
`default_nettype none

module sapsel_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [sapsel_pkg::IDX_W-1:0]     i_index,
    input  wire                              i_ins,
    input  wire  sapsel_pkg::t_entry         i_new,
    input  wire  [sapsel_pkg::CNT_W-1:0]     i_count,
    input  wire                              i_shift,
    input  wire  sapsel_pkg::t_link          i_prev,
    input  wire  sapsel_pkg::t_link          i_next,
    output sapsel_pkg::t_link                o_link
);
    import sapsel_pkg::*;

    logic   r_valid;
    t_entry r_ranked;
    t_entry r_arrival;
    logic   w_take;

    // The new point goes ahead of this cell's entry only if it is strictly
    // stronger, so equal strengths keep arrival order.
    assign w_take = i_ins && (!r_valid || (i_new.strength > r_ranked.strength));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end else if (w_take) begin
            r_valid <= i_prev.take ? i_prev.valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ranked <= i_next.ranked;
        end else if (w_take) begin
            r_ranked <= i_prev.take ? i_prev.ranked : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_arrival <= i_next.arrival;
        end else if (i_ins && (i_count == CNT_W'(i_index))) begin
            r_arrival <= i_new;
        end
    end

    assign o_link.valid   = r_valid;
    assign o_link.take    = w_take;
    assign o_link.ranked  = r_ranked;
    assign o_link.arrival = r_arrival;

endmodule

`default_nettype wire

/* rtl/strongest_access_point_select_core.sv */
// Strongest access point selection.
//
// The input channel (i_in_valid / o_in_ready) takes one scanned access point
// per word: address, strength and channel, with i_scan_end on the final point
// of a scan. Each accepted word goes straight into a chain of cells, so a scan
// streams in at one point per clock. The chain keeps the first points in
// arrival order and, in parallel, the strongest points sorted by strength,
// with earlier arrivals ahead on equal strength.
// After the word that carries i_scan_end, the block drains its report on the
// output channel (o_out_valid / i_out_ready): all points in arrival order when
// the scan had at most MAX_REPORT points, otherwise the MAX_REPORT strongest,
// strongest first. o_report_end marks the last word. The final point sets the
// drain flag; report words then pass from cell 0 into the output register, one
// word per cycle while the receiver takes them, and the chain shifts toward
// cell 0 once per word. The input stays stalled during the drain and opens
// again as soon as the last word sits in the output register. A stalling
// receiver simply holds the drain. Reset clears the cell valid bits, the point
// count and the drain control; stored points are not cleared.
`default_nettype none

module strongest_access_point_select_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [47:0]         i_ap_address,
    input  wire  signed [7:0]   i_ap_strength,
    input  wire  [7:0]          i_ap_channel,
    input  wire                 i_scan_end,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [47:0]         o_out_address,
    output logic signed [7:0]   o_out_strength,
    output logic [7:0]          o_out_channel,
    output logic                o_report_end
);
    import sapsel_pkg::*;

    // Point count of the current scan, saturating.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    // Drain control: words still to send and which list they come from.
    logic              r_drain;
    logic [LEFT_W-1:0] r_left;
    logic              r_use_arrival;
    logic              r_out_valid;
    t_entry            r_out;
    logic              r_out_end;

    logic              w_ins;
    logic              w_load;
    t_entry            w_new;
    t_entry            w_head;
    t_link             w_link [MAX_REPORT];
    t_link             w_prev [MAX_REPORT];
    t_link             w_next [MAX_REPORT];

    assign o_in_ready = !r_drain;
    assign w_ins      = i_in_valid && o_in_ready;

    // A report word moves into the output register whenever it is free or
    // being emptied in this cycle.
    assign w_load = r_drain && (!r_out_valid || i_out_ready);

    assign w_new.address  = i_ap_address;
    assign w_new.strength = i_ap_strength;
    assign w_new.channel  = i_ap_channel;

    assign n_count = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;

    genvar g;
    generate
        for (g = 0; g < MAX_REPORT; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g] = '0;
            end else begin : g_mid
                assign w_prev[g] = w_link[g-1];
            end
            if (g == MAX_REPORT - 1) begin : g_last
                assign w_next[g] = '0;
            end else begin : g_body
                assign w_next[g] = w_link[g+1];
            end

            sapsel_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(g)),
                .i_ins   (w_ins),
                .i_new   (w_new),
                .i_count (r_count),
                .i_shift (w_load),
                .i_prev  (w_prev[g]),
                .i_next  (w_next[g]),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    assign w_head = r_use_arrival ? w_link[0].arrival : w_link[0].ranked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_drain       <= 1'b0;
            r_left        <= '0;
            r_use_arrival <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_ins) begin
                if (i_scan_end) begin
                    // Either way the report holds min(count, MAX_REPORT) words.
                    r_count       <= '0;
                    r_drain       <= 1'b1;
                    r_use_arrival <= (n_count <= CNT_W'(MAX_REPORT));
                    if (n_count <= CNT_W'(MAX_REPORT)) begin
                        r_left <= LEFT_W'(n_count);
                    end else begin
                        r_left <= LEFT_W'(MAX_REPORT);
                    end
                end else begin
                    r_count <= n_count;
                end
            end
            if (w_load) begin
                r_left      <= r_left - 1'b1;
                r_out_valid <= 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    r_drain <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out     <= w_head;
            r_out_end <= (r_left == LEFT_W'(1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_address  = r_out.address;
    assign o_out_strength = r_out.strength;
    assign o_out_channel  = r_out.channel;
    assign o_report_end   = r_out_end;

endmodule

`default_nettype wire

/* rtl/sapsel_checker.sv */
`default_nettype none

module sapsel_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_ready,
    input wire               i_scan_end,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire [47:0]        o_out_address,
    input wire signed [7:0]  o_out_strength,
    input wire [7:0]         o_out_channel,
    input wire               o_report_end
);

    // A stalled report word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_address)
            && $stable(o_out_strength) && $stable(o_out_channel)
            && $stable(o_report_end))
        else $error("report word changed while stalled");

    // The final point of a scan closes the input until the report is drained.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_scan_end |=> !o_in_ready)
        else $error("input open right after scan end");

    // A report word that is not the last one is followed at once by the next.
    a_drain_goes_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_report_end |=> o_out_valid)
        else $error("report broke off before its end");

    // After reset the block is empty and waits for points.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("wrong state after reset");

endmodule

bind strongest_access_point_select_core sapsel_checker u_sapsel_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_scan_end    (i_scan_end),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_address (o_out_address),
    .o_out_strength(o_out_strength),
    .o_out_channel (o_out_channel),
    .o_report_end  (o_report_end)
);

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

// Testbench for the strongest access point selector. Scans of random length are streamed
// into the block with random gaps on the input side and random stalls on the output side.
// A tracker keeps its own view of every scan. It mirrors the arrival-order store, the
// strength ranking with earlier arrivals ahead on equal strength, and the saturating point
// count. From that view it builds the report that each final point must cause. Every
// report word that leaves the block is compared against the oldest word still owed.
module tb_top;

    import sapsel_pkg::*;

    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Quiet time after the last owed word, so that a stray extra word is still caught.
    localparam int DRAIN_SETTLE = 20;
    localparam int RANDOM_POINTS = 85;

    typedef struct {
        t_entry pt;
        logic   last;
    } t_report_word;

    // Tracks one scan at a time and holds the report words the block still owes.
    class ap_select_tracker;
        t_entry         arrival_q[$];
        t_entry         ranked_q[$];
        int unsigned    seen;
        t_report_word   owed_q[$];
        int unsigned    mismatches;

        function void note_scanned_point(t_entry pt, logic scan_last);
            int pos;
            int n;
            t_report_word w;
            if (arrival_q.size() < MAX_REPORT) begin
                arrival_q.push_back(pt);
            end
            // Walk past every kept point at least as strong; equal strength keeps the
            // earlier arrival ahead.
            pos = 0;
            while (pos < ranked_q.size() &&
                   $signed(ranked_q[pos].strength) >= $signed(pt.strength)) begin
                pos++;
            end
            if (pos < MAX_REPORT) begin
                ranked_q.insert(pos, pt);
                if (ranked_q.size() > MAX_REPORT) begin
                    void'(ranked_q.pop_back());
                end
            end
            if (seen < 255) begin
                seen++;
            end
            if (scan_last) begin
                // Short scans come back in arrival order, long ones strongest first.
                if (seen <= MAX_REPORT) begin
                    n = arrival_q.size();
                    for (int k = 0; k < n; k++) begin
                        w.pt = arrival_q[k];
                        w.last = (k == n - 1);
                        owed_q.push_back(w);
                    end
                end else begin
                    n = ranked_q.size();
                    for (int k = 0; k < n; k++) begin
                        w.pt = ranked_q[k];
                        w.last = (k == n - 1);
                        owed_q.push_back(w);
                    end
                end
                arrival_q.delete();
                ranked_q.delete();
                seen = 0;
            end
        endfunction

        function void check_report_word(t_entry got, logic got_end);
            t_report_word w;
            if (owed_q.size() == 0) begin
                $error("report word with none owed: address %h strength %0d channel %0d",
                       got.address, $signed(got.strength), got.channel);
                mismatches++;
                return;
            end
            w = owed_q.pop_front();
            if (got.address !== w.pt.address) begin
                $error("out_address: expected %h, got %h", w.pt.address, got.address);
                mismatches++;
            end
            if (got.strength !== w.pt.strength) begin
                $error("out_strength: expected %0d, got %0d",
                       $signed(w.pt.strength), $signed(got.strength));
                mismatches++;
            end
            if (got.channel !== w.pt.channel) begin
                $error("out_channel: expected %0d, got %0d", w.pt.channel, got.channel);
                mismatches++;
            end
            if (got_end !== w.last) begin
                $error("report_end: expected %0b, got %0b", w.last, got_end);
                mismatches++;
            end
        endfunction

        function int words_owed();
            return owed_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [47:0]        i_ap_address = '0;
    logic signed [7:0]  i_ap_strength = '0;
    logic [7:0]         i_ap_channel = '0;
    logic               i_scan_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [47:0]        o_out_address;
    logic signed [7:0]  o_out_strength;
    logic [7:0]         o_out_channel;
    logic               o_report_end;

    ap_select_tracker   tracker = new();
    int unsigned        quiet_cycles = 0;
    // Set per scan: when high the sender streams with no gaps at all.
    bit                 burst_mode = 1'b0;

    strongest_access_point_select_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_ap_address   (i_ap_address),
        .i_ap_strength  (i_ap_strength),
        .i_ap_channel   (i_ap_channel),
        .i_scan_end     (i_scan_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_address  (o_out_address),
        .o_out_strength (o_out_strength),
        .o_out_channel  (o_out_channel),
        .o_report_end   (o_report_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly back-to-back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offers one point and returns at the edge that accepts it. Valid is left high, so
    // the next call can drive the next word in the same step without a glitch.
    task automatic send_point(input t_entry pt, input logic scan_last);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_ap_address  <= pt.address;
        i_ap_strength <= pt.strength;
        i_ap_channel  <= pt.channel;
        i_scan_end    <= scan_last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        tracker.note_scanned_point(pt, scan_last);
    endtask

    function automatic t_entry random_point();
        t_entry pt;
        logic [63:0] raw;
        int r;
        raw = {$urandom(), $urandom()};
        r = $urandom_range(0, 19);
        if (r == 0) begin
            pt.address = '1;
        end else if (r == 1) begin
            pt.address = '0;
        end else begin
            pt.address = raw[47:0];
        end
        // A few strength levels recur often so that ties show up in the ranking.
        if ($urandom_range(0, 9) < 4) begin
            pt.strength = 8'(-40 - 10 * int'($urandom_range(0, 3)));
        end else begin
            pt.strength = 8'($urandom_range(0, 255));
        end
        pt.channel = 8'($urandom_range(0, 255));
        return pt;
    endfunction

    task automatic send_random_scan(input int len);
        burst_mode = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            send_point(random_point(), k == len - 1);
        end
    endtask

    // Receiver: runs of ready, broken by stalls of random length. Some runs are long so
    // that whole reports drain without a pause.
    initial begin
        int high_len;
        int low_len;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            high_len = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (high_len) @(posedge i_clk);
            low_len = pick_gap();
            if (low_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (low_len) @(posedge i_clk);
            end
        end
    end

    // Every report word is taken at the edge where valid and ready are both high; the
    // values read here are the ones that stood before that edge.
    always @(posedge i_clk) begin
        t_entry got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.address  = o_out_address;
            got.strength = o_out_strength;
            got.channel  = o_out_channel;
            tracker.check_report_word(got, o_report_end);
        end
    end

    // Hang detector: any cycle that moves a word on either side resets the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_entry pt;
        int sent;
        int len;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A scan of a single point, with every field at its top value.
        pt.address  = '1;
        pt.strength = 8'sd127;
        pt.channel  = 8'd255;
        send_point(pt, 1'b1);

        // Two points of equal strength: a short scan keeps arrival order.
        pt.address  = 48'h0000_0000_0001;
        pt.strength = -8'sd70;
        pt.channel  = 8'd1;
        send_point(pt, 1'b0);
        pt.address  = 48'h0000_0000_0002;
        pt.channel  = 8'd6;
        send_point(pt, 1'b1);

        // Sixteen points: the ranked report. Strength levels repeat to exercise tie
        // order, both extremes appear, and the final point is as weak as the weakest
        // kept one, so a full list must drop it.
        for (int k = 0; k < 16; k++) begin
            pt.address = (k == 0) ? 48'h0 : {16'hA5C3, 32'(k)};
            pt.channel = (k == 0) ? 8'd0 : 8'(k * 13);
            if (k == 0 || k == 14 || k == 15) begin
                pt.strength = -8'sd128;
            end else if (k == 13) begin
                pt.strength = 8'sd127;
            end else begin
                case (k % 3)
                    1:       pt.strength = 8'sd5;
                    2:       pt.strength = 8'sd0;
                    default: pt.strength = -8'sd1;
                endcase
            end
            send_point(pt, k == 15);
        end

        // Random scans. The first two sit on either side of the report-size boundary.
        send_random_scan(MAX_REPORT);
        send_random_scan(MAX_REPORT + 1);
        sent = 2 * MAX_REPORT + 1;
        while (sent < RANDOM_POINTS) begin
            len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, MAX_REPORT)
                                               : $urandom_range(MAX_REPORT + 1, 30);
            send_random_scan(len);
            sent += len;
        end
        i_in_valid <= 1'b0;

        while (tracker.words_owed() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
